FILE: design/gfmc_pkg.sv
`default_nettype none
package gfmc_pkg;

    localparam int PAYLOAD_BYTES = 6;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int CNT_W         = 4;
    localparam int DUTY_W        = 10;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]        START_MARKER_RST = 8'h80;
    localparam logic [CNT_W-1:0]  MISMATCH_RST     = 4'd10;
    localparam logic [7:0]        STICK_LOW_RST    = 8'h24;
    localparam logic [7:0]        STICK_HIGH_RST   = 8'h64;
    localparam logic [7:0]        STICK_RIGHT_RST  = 8'h7f;
    localparam logic [DUTY_W-1:0] DRIVE_DUTY_RST   = 10'd1023;
    localparam logic [7:0]        STICK_LEFT_VALUE = 8'h00;

    localparam int BTN_L1   = 1;
    localparam int BTN_R1   = 3;
    localparam int BTN_STOP = 4;
    localparam int BTN_X    = 5;
    localparam int BTN_O    = 6;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_START = 2'd1,
        ST_NO_SUM   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_START_MARKER   = 3'd0,
        REG_MISMATCH_LIMIT = 3'd1,
        REG_STICK_LOW      = 3'd2,
        REG_STICK_HIGH     = 3'd3,
        REG_STICK_RIGHT    = 3'd4,
        REG_DRIVE_DUTY     = 3'd5
    } t_reg_idx;

    typedef logic [PAYLOAD_BYTES-1:0][7:0] t_frame;

    typedef struct packed {
        t_status status;
        t_frame  frame;
    } t_job;

    typedef struct packed {
        logic [7:0]        start_marker;
        logic [CNT_W-1:0]  mismatch_limit;
        logic [7:0]        stick_low_bound;
        logic [7:0]        stick_high_bound;
        logic [7:0]        stick_right_value;
        logic [DUTY_W-1:0] drive_duty;
    } t_cfg;

endpackage
`default_nettype wire

FILE: design/gfmc_front.sv
`default_nettype none
module gfmc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_rx_byte,
    input  wire gfmc_pkg::t_cfg i_cfg,
    output logic               o_push,
    output gfmc_pkg::t_job     o_push_job
);
    import gfmc_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_DATA,
        PH_SUM
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [6:0]        r_sum, n_sum;
    t_frame            r_frame;

    logic [CNT_W-1:0]  cnt_inc;
    logic              miss_out;

    assign cnt_inc  = r_cnt + 1'b1;
    assign miss_out = (cnt_inc >= i_cfg.mismatch_limit);

    always_comb begin
        n_phase           = r_phase;
        n_idx             = r_idx;
        n_cnt             = r_cnt;
        n_sum             = r_sum;
        o_push            = 1'b0;
        o_push_job.status = ST_OK;
        o_push_job.frame  = r_frame;
        if (i_accept) begin
            case (r_phase)
                PH_DATA: begin
                    n_sum = r_sum + i_rx_byte[6:0];
                    n_idx = r_idx + 1'b1;
                    if (r_idx == IDX_W'(PAYLOAD_BYTES - 1)) begin
                        n_phase = PH_SUM;
                        n_cnt   = '0;
                    end
                end
                PH_SUM: begin
                    if (i_rx_byte == {1'b0, r_sum}) begin
                        n_phase           = PH_START;
                        n_cnt             = '0;
                        o_push            = 1'b1;
                        o_push_job.status = ST_OK;
                    end else if (miss_out) begin
                        n_phase           = PH_START;
                        n_cnt             = '0;
                        o_push            = 1'b1;
                        o_push_job.status = ST_NO_SUM;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                default: begin
                    n_phase = PH_START;
                    if (i_rx_byte == i_cfg.start_marker) begin
                        n_phase = PH_DATA;
                        n_idx   = '0;
                        n_sum   = '0;
                        n_cnt   = '0;
                    end else if (miss_out) begin
                        n_cnt             = '0;
                        o_push            = 1'b1;
                        o_push_job.status = ST_NO_START;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
        end
        if (i_accept && r_phase == PH_DATA) begin
            r_frame[r_idx] <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

FILE: design/gfmc_queue.sv
`default_nettype none
module gfmc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gfmc_pkg::t_job i_push_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output gfmc_pkg::t_job      o_pop_job,
    output logic                o_empty
);
    import gfmc_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;

    assign o_full    = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_job = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule
`default_nettype wire

FILE: design/gfmc_back.sv
`default_nettype none
module gfmc_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire gfmc_pkg::t_cfg              i_cfg,
    input  wire gfmc_pkg::t_job              i_job,
    input  wire logic                        i_empty,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [1:0]                       o_frame_status,
    output logic                             o_turret_direction,
    output logic [gfmc_pkg::DUTY_W-1:0]      o_turret_duty,
    output logic                             o_tire_direction,
    output logic [gfmc_pkg::DUTY_W-1:0]      o_tire_duty,
    output logic                             o_air_valve
);
    import gfmc_pkg::*;

    function automatic logic stick_aims(
        input logic [7:0] x,
        input logic [7:0] y,
        input logic [7:0] want,
        input logic [7:0] lo,
        input logic [7:0] hi
    );
        return (y < hi) && (y > lo) && (x == want);
    endfunction

    logic              r_valid;
    logic [1:0]        r_status;
    logic              r_tur_dir, n_tur_dir;
    logic [DUTY_W-1:0] r_tur_duty, n_tur_duty;
    logic              r_tire_dir, n_tire_dir;
    logic [DUTY_W-1:0] r_tire_duty, n_tire_duty;
    logic              r_valve, n_valve;

    logic [7:0] b0, b1, lx, ly, rx, ry;
    logic       aim_right, aim_left;

    assign b0 = i_job.frame[0];
    assign b1 = i_job.frame[1];
    assign lx = i_job.frame[2];
    assign ly = i_job.frame[3];
    assign rx = i_job.frame[4];
    assign ry = i_job.frame[5];

    assign aim_right = stick_aims(rx, ry, i_cfg.stick_right_value,
                                  i_cfg.stick_low_bound, i_cfg.stick_high_bound)
                    || stick_aims(lx, ly, i_cfg.stick_right_value,
                                  i_cfg.stick_low_bound, i_cfg.stick_high_bound);
    assign aim_left  = stick_aims(rx, ry, STICK_LEFT_VALUE,
                                  i_cfg.stick_low_bound, i_cfg.stick_high_bound)
                    || stick_aims(lx, ly, STICK_LEFT_VALUE,
                                  i_cfg.stick_low_bound, i_cfg.stick_high_bound);

    assign o_pop = !i_empty && (!r_valid || !i_stall);

    always_comb begin
        n_tur_dir   = r_tur_dir;
        n_tur_duty  = r_tur_duty;
        n_tire_dir  = r_tire_dir;
        n_tire_duty = r_tire_duty;
        n_valve     = r_valve;
        if (i_job.status == ST_OK) begin
            if (b0[BTN_R1]) begin
                n_tur_dir  = 1'b1;
                n_tur_duty = i_cfg.drive_duty;
            end else if (b0[BTN_L1]) begin
                n_tur_dir  = 1'b0;
                n_tur_duty = i_cfg.drive_duty;
            end
            if (b1[BTN_O]) begin
                n_valve = 1'b1;
            end else if (b1[BTN_X]) begin
                n_valve = 1'b0;
            end
            if (aim_right) begin
                n_tire_dir  = 1'b1;
                n_tire_duty = i_cfg.drive_duty;
            end else if (aim_left) begin
                n_tire_dir  = 1'b0;
                n_tire_duty = i_cfg.drive_duty;
            end else if (b1[BTN_STOP]) begin
                n_tire_duty = '0;
                n_tur_duty  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_status    <= ST_OK;
            r_tur_dir   <= 1'b0;
            r_tur_duty  <= '0;
            r_tire_dir  <= 1'b0;
            r_tire_duty <= '0;
            r_valve     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid     <= 1'b1;
                r_status    <= i_job.status;
                r_tur_dir   <= n_tur_dir;
                r_tur_duty  <= n_tur_duty;
                r_tire_dir  <= n_tire_dir;
                r_tire_duty <= n_tire_duty;
                r_valve     <= n_valve;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_frame_status     = r_status;
    assign o_turret_direction = r_tur_dir;
    assign o_turret_duty      = r_tur_duty;
    assign o_tire_direction   = r_tire_dir;
    assign o_tire_duty        = r_tire_duty;
    assign o_air_valve        = r_valve;

endmodule
`default_nettype wire

FILE: design/gamepad_frame_to_motor_commands.sv
`default_nettype none
// Gamepad frame receiver and motor command decoder. Serial bytes enter on
// i_rx_byte, one per cycle at full rate; each byte is taken in the cycle it is
// offered unless the two-entry queue between the frame parser and the command
// decoder is full, which is what raises o_stall. A result (one per good frame,
// failed start hunt or failed checksum hunt) is queued as the byte that closes
// it is transferred, then moves into the output register that drives o_valid.
// The decoder fills that register with one result per cycle unless the output
// stalls, so an output stall reaches o_stall only once the output register and
// both queue entries hold results. The command fields are held registers: they
// change only with a good frame. APB registers sit at byte addresses 0x00 to
// 0x14; the user must write them only while idle: the block does not check.
module gamepad_frame_to_motor_commands (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [7:0]             i_rx_byte,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [1:0]                  o_frame_status,
    output logic                        o_turret_direction,
    output logic [9:0]                  o_turret_duty,
    output logic                        o_tire_direction,
    output logic [9:0]                  o_tire_duty,
    output logic                        o_air_valve,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [4:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import gfmc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     in_accept;
    logic     push, full, pop, empty;
    t_job     push_job, pop_job;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker      <= START_MARKER_RST;
            r_cfg.mismatch_limit    <= MISMATCH_RST;
            r_cfg.stick_low_bound   <= STICK_LOW_RST;
            r_cfg.stick_high_bound  <= STICK_HIGH_RST;
            r_cfg.stick_right_value <= STICK_RIGHT_RST;
            r_cfg.drive_duty        <= DRIVE_DUTY_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_START_MARKER:   r_cfg.start_marker      <= pwdata[7:0];
                REG_MISMATCH_LIMIT: r_cfg.mismatch_limit    <= pwdata[CNT_W-1:0];
                REG_STICK_LOW:      r_cfg.stick_low_bound   <= pwdata[7:0];
                REG_STICK_HIGH:     r_cfg.stick_high_bound  <= pwdata[7:0];
                REG_STICK_RIGHT:    r_cfg.stick_right_value <= pwdata[7:0];
                REG_DRIVE_DUTY:     r_cfg.drive_duty        <= pwdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START_MARKER:   prdata = {24'd0, r_cfg.start_marker};
            REG_MISMATCH_LIMIT: prdata = {28'd0, r_cfg.mismatch_limit};
            REG_STICK_LOW:      prdata = {24'd0, r_cfg.stick_low_bound};
            REG_STICK_HIGH:     prdata = {24'd0, r_cfg.stick_high_bound};
            REG_STICK_RIGHT:    prdata = {24'd0, r_cfg.stick_right_value};
            REG_DRIVE_DUTY:     prdata = {22'd0, r_cfg.drive_duty};
            default:            prdata = '0;
        endcase
    end

    assign o_stall   = full;
    assign in_accept = i_valid && !o_stall;

    gfmc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (r_cfg),
        .o_push     (push),
        .o_push_job (push_job)
    );

    gfmc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_pop_job  (pop_job),
        .o_empty    (empty)
    );

    gfmc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_job              (pop_job),
        .i_empty            (empty),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_frame_status     (o_frame_status),
        .o_turret_direction (o_turret_direction),
        .o_turret_duty      (o_turret_duty),
        .o_tire_direction   (o_tire_direction),
        .o_tire_duty        (o_tire_duty),
        .o_air_valve        (o_air_valve)
    );

endmodule
`default_nettype wire

FILE: design/gfmc_checker.sv
`default_nettype none
module gfmc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_frame_status,
    input wire logic        o_turret_direction,
    input wire logic [9:0]  o_turret_duty,
    input wire logic        o_tire_direction,
    input wire logic [9:0]  o_tire_duty,
    input wire logic        o_air_valve
);
    import gfmc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_status)
            && $stable(o_turret_duty) && $stable(o_tire_duty))
        else $error("stalled result changed");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_status == ST_OK || o_frame_status == ST_NO_START
            || o_frame_status == ST_NO_SUM))
        else $error("illegal frame status");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("handshake active after reset");

    a_reset_cmds: assert property (@(posedge i_clk)
        !i_rst_n |=> o_turret_duty == '0 && o_tire_duty == '0 && !o_air_valve
            && !o_turret_direction && !o_tire_direction)
        else $error("commands not cleared by reset");

endmodule

bind gamepad_frame_to_motor_commands gfmc_checker u_gfmc_checker (.*);
`default_nettype wire
